/* src/wmcd_pkg.sv */
// Shared types, constants and register codes for the windowed majority color detector.
`default_nettype none

package wmcd_pkg;

  // History ring
  localparam int HIST_DEPTH = 64;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int HIST_FW    = $clog2(HIST_DEPTH + 1);

  // Queue between classifier and history engine
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Class codes
  localparam logic [1:0] CLS_UNKNOWN = 2'd0;
  localparam logic [1:0] CLS_SAFE    = 2'd1;
  localparam logic [1:0] CLS_ATTACK  = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_FLOOR       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_CEILING   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE_CEILING    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_GREEN_RATIO = 3'd4;

  // Reset values of the registers
  localparam logic [15:0] RST_WINDOW_MS       = 16'd1000;
  localparam logic [11:0] RST_RED_FLOOR       = 12'd2560;
  localparam logic [11:0] RST_GREEN_CEILING   = 12'd2720;
  localparam logic [11:0] RST_BLUE_CEILING    = 12'd2080;
  localparam logic [9:0]  RST_RED_GREEN_RATIO = 10'd461;

  typedef struct packed {
    logic [11:0] average_red;
    logic [11:0] average_green;
    logic [11:0] average_blue;
    logic [31:0] timestamp_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0] filtered_class;
    logic [1:0] frame_class;
    logic       class_changed;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_wr_t;

  typedef struct packed {
    logic [15:0] window_ms;
    logic [11:0] red_floor;
    logic [11:0] green_ceiling;
    logic [11:0] blue_ceiling;
    logic [9:0]  red_green_ratio;
  } cfg_t;

  // Classified frame; also the layout of one history entry
  typedef struct packed {
    logic [31:0] timestamp_ms;
    logic [1:0]  frame_class;
  } job_t;

endpackage

`default_nettype wire

/* src/wmcd_if.sv */
// Valid/ready channel interfaces: input frames, results and register writes.
`default_nettype none

interface wmcd_in_if;
  import wmcd_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface wmcd_out_if;
  import wmcd_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface wmcd_cfg_if;
  import wmcd_pkg::*;
  logic    valid;
  logic    ready;
  cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/windowed_majority_color_detector.sv */
// Top level of the windowed majority color detector: registers, front end, queue, back end.
//
//   channel  dir  payload                                          transaction
//   in_i     in   average_red/green/blue (u8.4), timestamp_ms      valid & ready
//   out_o    out  filtered_class, frame_class, class_changed       valid & ready
//   cfg_i    in   index (3b), value (16b)                          valid & ready, ready tied 1
//
// Flow: the front end registers a frame and classifies it from that register; the
// history engine then pops it, checks the oldest entry once per age eviction plus a
// final check through the single read port of the history ring, appends and reports.
// Reset clears pointers, fill and counts; the ring itself is never cleared, only held
// entries are read. A stalled result waits in the output register while the front end
// and the two-entry queue keep taking frames until the queue is full.
`default_nettype none

module windowed_majority_color_detector (
  input  logic       clk_i,
  input  logic       rst_ni,
  wmcd_in_if.sink    in_i,
  wmcd_out_if.source out_o,
  wmcd_cfg_if.sink   cfg_i
);
  import wmcd_pkg::*;

  cfg_t cfg_q, cfg_d;

  logic push_valid, push_ready;
  job_t push_job;
  logic pop_valid, pop_ready;
  job_t pop_job;

  // register writes are always taken; unknown indexes are dropped
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.data.index)
        CFG_WINDOW_MS:       cfg_d.window_ms       = cfg_i.data.value;
        CFG_RED_FLOOR:       cfg_d.red_floor       = cfg_i.data.value[11:0];
        CFG_GREEN_CEILING:   cfg_d.green_ceiling   = cfg_i.data.value[11:0];
        CFG_BLUE_CEILING:    cfg_d.blue_ceiling    = cfg_i.data.value[11:0];
        CFG_RED_GREEN_RATIO: cfg_d.red_green_ratio = cfg_i.data.value[9:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_ms       <= RST_WINDOW_MS;
      cfg_q.red_floor       <= RST_RED_FLOOR;
      cfg_q.green_ceiling   <= RST_GREEN_CEILING;
      cfg_q.blue_ceiling    <= RST_BLUE_CEILING;
      cfg_q.red_green_ratio <= RST_RED_GREEN_RATIO;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  wmcd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_q),
    .push_valid_o (push_valid),
    .push_job_o   (push_job),
    .push_ready_i (push_ready)
  );

  wmcd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_job_i   (push_job),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_job_o    (pop_job),
    .pop_ready_i  (pop_ready)
  );

  wmcd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_job_i   (pop_job),
    .pop_ready_o (pop_ready),
    .window_ms_i (cfg_q.window_ms),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

/* src/wmcd_front.sv */
// Front end: input stage register and color threshold classifier.
`default_nettype none

module wmcd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  wmcd_in_if.sink          in_i,
  input  wmcd_pkg::cfg_t   cfg_i,
  output logic             push_valid_o,
  output wmcd_pkg::job_t   push_job_o,
  input  logic             push_ready_i
);
  import wmcd_pkg::*;

  logic     stage_valid_q, stage_valid_d;
  in_item_t stage_q;
  logic     load;
  logic [21:0] red_scaled;
  logic [21:0] green_scaled;
  logic        thresh_safe;
  logic        ratio_safe;

  assign in_i.ready = !stage_valid_q || push_ready_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    stage_valid_d = stage_valid_q;
    if (load) begin
      stage_valid_d = 1'b1;
    end else if (push_ready_i) begin
      stage_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      stage_q <= in_i.data;
    end
  end

  // red * 256 against green * ratio, exact
  assign red_scaled   = {2'b00, stage_q.average_red, 8'b0};
  assign green_scaled = 22'(stage_q.average_green * cfg_i.red_green_ratio);

  assign thresh_safe = (stage_q.average_red < cfg_i.red_floor)
                    || (stage_q.average_green > cfg_i.green_ceiling)
                    || (stage_q.average_blue > cfg_i.blue_ceiling);
  assign ratio_safe  = red_scaled < green_scaled;

  assign push_valid_o            = stage_valid_q;
  assign push_job_o.timestamp_ms = stage_q.timestamp_ms;
  assign push_job_o.frame_class  = (thresh_safe || ratio_safe) ? CLS_SAFE : CLS_ATTACK;

endmodule

`default_nettype wire

/* src/wmcd_queue.sv */
// Short FIFO of classified frames between front end and history engine.
`default_nettype none

module wmcd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  wmcd_pkg::job_t push_job_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output wmcd_pkg::job_t pop_job_o,
  input  logic           pop_ready_i
);
  import wmcd_pkg::*;

  job_t                entries_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CW-1:0] count_q, count_d;
  logic                push, pop;

  assign push_ready_o = count_q != QUEUE_CW'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_job_o    = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

`default_nettype wire

/* src/wmcd_back.sv */
// Back end: history ring, age eviction, class counts, majority vote and result register.
`default_nettype none

module wmcd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  input  wmcd_pkg::job_t pop_job_i,
  output logic           pop_ready_o,
  input  logic [15:0]    window_ms_i,
  wmcd_out_if.source     out_o
);
  import wmcd_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CHECK  = 2'd1;
  localparam logic [1:0] ST_APPEND = 2'd2;
  localparam logic [1:0] ST_REPORT = 2'd3;
  localparam int TW = HIST_FW + 1;

  logic [1:0]         state_q, state_d;
  logic [HIST_AW-1:0] head_q, head_d;
  logic [HIST_FW-1:0] fill_q, fill_d;
  logic [HIST_FW-1:0] cnt_safe_q, cnt_safe_d;
  logic [HIST_FW-1:0] cnt_attack_q, cnt_attack_d;
  logic [1:0]         reported_q, reported_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;
  job_t               job_q, job_d;
  job_t               rd_q;

  job_t               mem [HIST_DEPTH];
  logic               wr_en;
  logic [HIST_AW-1:0] tail;
  logic [TW-1:0]      tail_sum;
  logic [HIST_AW-1:0] head_inc;
  logic               full;
  logic               too_old;
  logic               drop;
  logic [1:0]         best;

  assign tail_sum = TW'(head_q) + TW'(fill_q);
  assign tail     = (tail_sum >= TW'(HIST_DEPTH)) ? HIST_AW'(tail_sum - TW'(HIST_DEPTH))
                                                  : HIST_AW'(tail_sum);
  assign head_inc = (head_q == HIST_AW'(HIST_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign full     = fill_q == HIST_FW'(HIST_DEPTH);

  // oldest entry's time plus window, without wrap, against the new time
  assign too_old = ({1'b0, rd_q.timestamp_ms} + {17'b0, window_ms_i})
                 < {1'b0, job_q.timestamp_ms};

  // ties go to the lower code
  always_comb begin
    if (cnt_attack_q > cnt_safe_q) begin
      best = CLS_ATTACK;
    end else if (cnt_safe_q != '0) begin
      best = CLS_SAFE;
    end else begin
      best = CLS_UNKNOWN;
    end
  end

  assign pop_ready_o = state_q == ST_IDLE;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    fill_d       = fill_q;
    cnt_safe_d   = cnt_safe_q;
    cnt_attack_d = cnt_attack_q;
    reported_d   = reported_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    job_d        = job_q;
    wr_en        = 1'b0;
    drop         = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          job_d   = pop_job_i;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (fill_q != '0 && too_old) begin
          drop   = 1'b1;
          head_d = head_inc;
          fill_d = fill_q - 1'b1;
        end else begin
          state_d = ST_APPEND;
        end
      end
      ST_APPEND: begin
        wr_en = 1'b1;
        if (full) begin
          drop   = 1'b1;
          head_d = head_inc;
        end else begin
          fill_d = fill_q + 1'b1;
        end
        if (job_q.frame_class == CLS_SAFE) begin
          cnt_safe_d = cnt_safe_d + 1'b1;
        end else begin
          cnt_attack_d = cnt_attack_d + 1'b1;
        end
        state_d = ST_REPORT;
      end
      ST_REPORT: begin
        if (!out_valid_q || out_o.ready) begin
          out_d.filtered_class = best;
          out_d.frame_class    = job_q.frame_class;
          out_d.class_changed  = best != reported_q;
          out_valid_d          = 1'b1;
          reported_d           = best;
          state_d              = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // decrement for the dropped oldest entry
    if (drop) begin
      if (rd_q.frame_class == CLS_SAFE) begin
        cnt_safe_d = cnt_safe_d - 1'b1;
      end else if (rd_q.frame_class == CLS_ATTACK) begin
        cnt_attack_d = cnt_attack_d - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      head_q       <= '0;
      fill_q       <= '0;
      cnt_safe_q   <= '0;
      cnt_attack_q <= '0;
      reported_q   <= CLS_UNKNOWN;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      fill_q       <= fill_d;
      cnt_safe_q   <= cnt_safe_d;
      cnt_attack_q <= cnt_attack_d;
      reported_q   <= reported_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    out_q <= out_d;
  end

  // history ring; read port follows the next head so the oldest entry is ready each cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[tail] <= job_q;
    end
    rd_q <= mem[head_d];
  end

endmodule

`default_nettype wire
